// ===== rtl/cfcap_pkg.sv =====
// Shared types, codes and constants of the CAN frame capture and trigger block.
package cfcap_pkg;

    // default sizing
    localparam int PAGE_BYTES_DEF  = 256;
    localparam int ENTRY_BYTES_DEF = 20;
    localparam int LOG_PAGES_DEF   = 4096;

    localparam int NUM_BUSES  = 6;
    localparam int KIB_SHIFT  = 10;
    localparam int BUDGET_W   = 27;
    localparam int PADDR_W    = 5;

    localparam logic [5:0] BUS_EN_RST = 6'h3F;

    // command codes
    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_ARM   = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // run states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_REC   = 2'd1;
    localparam logic [1:0] ST_ARMED = 2'd2;
    localparam logic [1:0] ST_CAPT  = 2'd3;

    localparam logic [1:0] MODE_TRIGGERED = 2'd2;

    // trigger byte tests
    localparam logic [2:0] CMP_ANY  = 3'd0;
    localparam logic [2:0] CMP_EQ   = 3'd1;
    localparam logic [2:0] CMP_GT   = 3'd2;
    localparam logic [2:0] CMP_LT   = 3'd3;
    localparam logic [2:0] CMP_MASK = 3'd4;

    // register indexes
    localparam logic [2:0] REG_BUS_EN     = 3'd0;
    localparam logic [2:0] REG_LOG_MODE   = 3'd1;
    localparam logic [2:0] REG_TRIG_BUS   = 3'd2;
    localparam logic [2:0] REG_TRIG_IDENT = 3'd3;
    localparam logic [2:0] REG_TRIG_INDEX = 3'd4;
    localparam logic [2:0] REG_TRIG_CMP   = 3'd5;
    localparam logic [2:0] REG_TRIG_OPND  = 3'd6;
    localparam logic [2:0] REG_POST_KIB   = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  src_bus;
        logic [28:0] frame_ident;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic        logged;
        logic [31:0] rel_time;
        logic [3:0]  slot;
        logic        page_done;
        logic [11:0] page_number;
        logic        trigger_hit;
        logic        capture_end;
        logic [1:0]  mode_now;
        logic [31:0] total_entries;
        logic [31:0] total_wraps;
    } t_out_word;

    typedef struct packed {
        logic [5:0]  bus_enable;
        logic [1:0]  log_mode;
        logic [7:0]  trig_bus;
        logic [28:0] trig_ident;
        logic [2:0]  trig_byte_index;
        logic [2:0]  trig_compare;
        logic [7:0]  trig_operand;
        logic [15:0] post_kib;
    } t_cfg;

    localparam t_cfg CFG_RST = '{bus_enable: BUS_EN_RST, log_mode: 2'd0, trig_bus: 8'd0,
                                 trig_ident: 29'd0, trig_byte_index: 3'd0,
                                 trig_compare: 3'd0, trig_operand: 8'd0,
                                 post_kib: 16'd0};

endpackage

// ===== rtl/cfcap_trig.sv =====
// Trigger match: bus, identifier and payload byte test against the trigger registers.
module cfcap_trig (
    input  cfcap_pkg::t_cfg       i_cfg,
    input  logic [2:0]            i_bus,
    input  logic [28:0]           i_ident,
    input  logic [3:0]            i_dlc,
    input  logic [63:0]           i_payload,
    output logic                  o_match
);
    import cfcap_pkg::*;

    logic [7:0] w_byte;
    logic       w_addr_ok;
    logic       w_byte_ok;
    logic       w_in_len;

    assign w_byte    = i_payload[i_cfg.trig_byte_index*8 +: 8];
    assign w_addr_ok = ({5'd0, i_bus} == i_cfg.trig_bus) && (i_ident == i_cfg.trig_ident);
    // a byte beyond the length code never passes a value test
    assign w_in_len  = ({1'b0, i_cfg.trig_byte_index} < i_dlc);

    always_comb begin
        case (i_cfg.trig_compare)
            CMP_ANY:  w_byte_ok = 1'b1;
            CMP_EQ:   w_byte_ok = w_in_len && (w_byte == i_cfg.trig_operand);
            CMP_GT:   w_byte_ok = w_in_len && (w_byte > i_cfg.trig_operand);
            CMP_LT:   w_byte_ok = w_in_len && (w_byte < i_cfg.trig_operand);
            CMP_MASK: w_byte_ok = w_in_len && ((w_byte & i_cfg.trig_operand) != 8'd0);
            default:  w_byte_ok = 1'b0;
        endcase
    end

    assign o_match = w_addr_ok && w_byte_ok;

endmodule

// ===== rtl/can_frame_capture_trigger.sv =====
// Channel  | Signals                                  | Direction
// ---------+------------------------------------------+----------
// in       | i_in_valid, o_in_ready, i_in_word        | word in
// out      | o_out_valid, i_out_ready, o_out_word     | word out
// config   | psel, penable, pwrite, paddr, pwdata,    | APB slave
//          | prdata, pready                           |
//
// One word per cycle sustained while the output is not stalled; a word passes
// the input register, then the state update that loads the result register.
// The run state, page fill and counters update in the same cycle that loads
// the result register, so back-to-back words see each other's effects.
// A stalled output holds the result register and the input register; the
// input side stalls only when both are full. Reset clears state and valid flags.
module can_frame_capture_trigger #(
    parameter int PAGE_BYTES  = cfcap_pkg::PAGE_BYTES_DEF,
    parameter int ENTRY_BYTES = cfcap_pkg::ENTRY_BYTES_DEF,
    parameter int LOG_PAGES   = cfcap_pkg::LOG_PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cfcap_pkg::t_in_word           i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cfcap_pkg::t_out_word          o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfcap_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cfcap_pkg::*;

    localparam int PER_PAGE = PAGE_BYTES / ENTRY_BYTES;
    localparam int FILL_W   = $clog2(PER_PAGE + 1);
    localparam int PTR_W    = (LOG_PAGES > 2) ? $clog2(LOG_PAGES) : 1;

    // ---------------- configuration registers ----------------
    t_cfg       r_cfg;
    logic [2:0] w_reg_idx;
    logic       w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_BUS_EN:     r_cfg.bus_enable      <= pwdata[5:0];
                REG_LOG_MODE:   r_cfg.log_mode        <= pwdata[1:0];
                REG_TRIG_BUS:   r_cfg.trig_bus        <= pwdata[7:0];
                REG_TRIG_IDENT: r_cfg.trig_ident      <= pwdata[28:0];
                REG_TRIG_INDEX: r_cfg.trig_byte_index <= pwdata[2:0];
                REG_TRIG_CMP:   r_cfg.trig_compare    <= pwdata[2:0];
                REG_TRIG_OPND:  r_cfg.trig_operand    <= pwdata[7:0];
                REG_POST_KIB:   r_cfg.post_kib        <= pwdata[15:0];
                default:        r_cfg.bus_enable      <= r_cfg.bus_enable;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_BUS_EN:     prdata = {26'd0, r_cfg.bus_enable};
            REG_LOG_MODE:   prdata = {30'd0, r_cfg.log_mode};
            REG_TRIG_BUS:   prdata = {24'd0, r_cfg.trig_bus};
            REG_TRIG_IDENT: prdata = {3'd0, r_cfg.trig_ident};
            REG_TRIG_INDEX: prdata = {29'd0, r_cfg.trig_byte_index};
            REG_TRIG_CMP:   prdata = {29'd0, r_cfg.trig_compare};
            REG_TRIG_OPND:  prdata = {24'd0, r_cfg.trig_operand};
            REG_POST_KIB:   prdata = {16'd0, r_cfg.post_kib};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    logic     r_in_valid;
    t_in_word r_in_word;
    logic     r_out_valid;
    t_out_word r_out_word;
    logic     w_adv;
    logic     w_step;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign w_step      = r_in_valid && w_adv;
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    // ---------------- capture state ----------------
    logic [1:0]          r_state,  n_state;
    logic [31:0]         r_start,  n_start;
    logic [FILL_W-1:0]   r_fill,   n_fill;
    logic [PTR_W-1:0]    r_ptr,    n_ptr;
    logic [31:0]         r_wraps,  n_wraps;
    logic [31:0]         r_entries, n_entries;
    logic [BUDGET_W-1:0] r_budget, n_budget;

    logic                w_match;
    logic [7:0]          w_mask8;
    logic [FILL_W-1:0]   w_fill_inc;
    logic [31:0]         w_slot_ext;
    logic [31:0]         w_ptr_ext;
    logic                w_flush;
    t_out_word           n_out;

    cfcap_trig u_trig (
        .i_cfg     (r_cfg),
        .i_bus     (r_in_word.src_bus),
        .i_ident   (r_in_word.frame_ident),
        .i_dlc     (r_in_word.length_code),
        .i_payload (r_in_word.payload),
        .o_match   (w_match)
    );

    assign w_mask8    = {2'b00, r_cfg.bus_enable};
    assign w_fill_inc = r_fill + FILL_W'(1);
    assign w_slot_ext = 32'(r_fill);
    assign w_ptr_ext  = 32'(r_ptr);

    always_comb begin
        n_state   = r_state;
        n_start   = r_start;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_wraps   = r_wraps;
        n_entries = r_entries;
        n_budget  = r_budget;
        w_flush   = 1'b0;
        n_out     = '0;

        unique case (r_in_word.command)
            CMD_FRAME: begin
                if (r_state != ST_IDLE && {5'd0, r_in_word.src_bus} < 8'(NUM_BUSES)
                        && w_mask8[r_in_word.src_bus]) begin
                    n_out.logged   = 1'b1;
                    n_out.rel_time = r_in_word.now_ms - r_start;
                    n_out.slot     = w_slot_ext[3:0];
                    n_fill         = w_fill_inc;
                    // page cannot take another entry: flush it
                    if (w_fill_inc >= FILL_W'(PER_PAGE)) begin
                        w_flush = 1'b1;
                    end
                    if (r_entries != 32'hFFFF_FFFF) begin
                        n_entries = r_entries + 32'd1;
                    end
                    if (r_state == ST_ARMED) begin
                        if (w_match) begin
                            n_out.trigger_hit = 1'b1;
                            n_budget = BUDGET_W'(r_cfg.post_kib) << KIB_SHIFT;
                            n_state  = ST_CAPT;
                        end
                    end else if (r_state == ST_CAPT) begin
                        if (r_budget <= BUDGET_W'(ENTRY_BYTES)) begin
                            // budget spent: stop and flush the page in progress
                            n_state           = ST_IDLE;
                            w_flush           = 1'b1;
                            n_out.capture_end = 1'b1;
                        end else begin
                            n_budget = r_budget - BUDGET_W'(ENTRY_BYTES);
                        end
                    end
                end
            end
            CMD_START: begin
                if (r_state != ST_REC) begin
                    n_start = r_in_word.now_ms;
                    n_state = ST_REC;
                    n_fill  = '0;
                end
            end
            CMD_ARM: begin
                if (r_state == ST_IDLE && r_cfg.log_mode == MODE_TRIGGERED) begin
                    n_start  = r_in_word.now_ms;
                    n_state  = ST_ARMED;
                    n_fill   = '0;
                    n_budget = '0;
                end
            end
            CMD_STOP: begin
                if (r_state != ST_IDLE) begin
                    n_state = ST_IDLE;
                    w_flush = (r_fill != '0);
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase

        if (w_flush) begin
            n_out.page_done   = 1'b1;
            n_out.page_number = w_ptr_ext[11:0];
            n_fill            = '0;
            if (r_ptr == PTR_W'(LOG_PAGES - 1)) begin
                n_ptr   = '0;
                n_wraps = r_wraps + 32'd1;
            end else begin
                n_ptr = r_ptr + PTR_W'(1);
            end
        end

        n_out.mode_now      = n_state;
        n_out.total_entries = n_entries;
        n_out.total_wraps   = n_wraps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_wraps     <= '0;
            r_entries   <= '0;
            r_budget    <= '0;
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_wraps     <= n_wraps;
            r_entries   <= n_entries;
            r_budget    <= n_budget;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_word <= n_out;
        end
    end

    // ---------------- checks ----------------
    a_idle_page_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fill == '0))
        else $error("partial page held while idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(PER_PAGE))
        else $error("page fill beyond page capacity");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.capture_end) |->
            (r_out_word.mode_now == ST_IDLE && r_out_word.page_done))
        else $error("capture end without idle and flush");

    a_hit_capt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.trigger_hit) |->
            (r_out_word.mode_now == ST_CAPT && r_out_word.logged))
        else $error("trigger hit without capture");

    a_wrap_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wraps != $past(r_wraps)) |-> ($past(w_step) && r_ptr == '0))
        else $error("wrap count moved without pointer wrap");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the CAN frame capture and trigger block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfcap_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 73;

    class frame_log_checker;
        t_cfg                cfg;
        logic [1:0]          run_state;
        logic [31:0]         start_time;
        logic [3:0]          fill;
        logic [11:0]         page_ptr;
        logic [31:0]         wraps;
        logic [31:0]         entries;
        logic [BUDGET_W-1:0] budget;
        t_out_word           expected_q[$];
        int                  errors;
        int                  words_in;
        int                  logged_cnt;
        int                  flush_cnt;
        int                  hit_cnt;
        int                  end_cnt;

        function new();
            cfg = '0;
            cfg.bus_enable = BUS_EN_RST;
            run_state = ST_IDLE;
            start_time = '0;
            fill = '0;
            page_ptr = '0;
            wraps = '0;
            entries = '0;
            budget = '0;
            errors = 0;
            words_in = 0;
            logged_cnt = 0;
            flush_cnt = 0;
            hit_cnt = 0;
            end_cnt = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_BUS_EN:     cfg.bus_enable = v[5:0];
                REG_LOG_MODE:   cfg.log_mode = v[1:0];
                REG_TRIG_BUS:   cfg.trig_bus = v[7:0];
                REG_TRIG_IDENT: cfg.trig_ident = v[28:0];
                REG_TRIG_INDEX: cfg.trig_byte_index = v[2:0];
                REG_TRIG_CMP:   cfg.trig_compare = v[2:0];
                REG_TRIG_OPND:  cfg.trig_operand = v[7:0];
                default:        cfg.post_kib = v[15:0];
            endcase
        endfunction

        function logic [31:0] reg_image(logic [2:0] idx);
            case (idx)
                REG_BUS_EN:     return 32'(cfg.bus_enable);
                REG_LOG_MODE:   return 32'(cfg.log_mode);
                REG_TRIG_BUS:   return 32'(cfg.trig_bus);
                REG_TRIG_IDENT: return 32'(cfg.trig_ident);
                REG_TRIG_INDEX: return 32'(cfg.trig_byte_index);
                REG_TRIG_CMP:   return 32'(cfg.trig_compare);
                REG_TRIG_OPND:  return 32'(cfg.trig_operand);
                default:        return 32'(cfg.post_kib);
            endcase
        endfunction

        // an empty page is never flushed; a second flush in one step is a no-op
        function void close_page(inout t_out_word r);
            if (fill == '0)
                return;
            r.page_done = 1'b1;
            r.page_number = page_ptr;
            flush_cnt++;
            if (int'(page_ptr) + 1 >= LOG_PAGES_DEF) begin
                page_ptr = '0;
                wraps++;
            end else begin
                page_ptr++;
            end
            fill = '0;
        endfunction

        function bit fires(t_in_word w);
            int         idx;
            logic [7:0] b;
            idx = int'(cfg.trig_byte_index);
            b = w.payload[8*idx +: 8];
            if ({5'b0, w.src_bus} != cfg.trig_bus)
                return 1'b0;
            if (w.frame_ident != cfg.trig_ident)
                return 1'b0;
            if (cfg.trig_compare == CMP_ANY)
                return 1'b1;
            if (cfg.trig_compare > CMP_MASK)
                return 1'b0;
            if (idx >= int'(w.length_code))
                return 1'b0;
            case (cfg.trig_compare)
                CMP_EQ:  return b == cfg.trig_operand;
                CMP_GT:  return b > cfg.trig_operand;
                CMP_LT:  return b < cfg.trig_operand;
                default: return (b & cfg.trig_operand) != 8'd0;
            endcase
        endfunction

        function void log_command(t_in_word w);
            t_out_word  r;
            logic [1:0] st;
            r = '0;
            st = run_state;
            words_in++;
            case (w.command)
                CMD_FRAME: begin
                    if (st != ST_IDLE && w.src_bus < NUM_BUSES
                            && cfg.bus_enable[w.src_bus]) begin
                        r.logged = 1'b1;
                        r.rel_time = w.now_ms - start_time;
                        r.slot = fill;
                        logged_cnt++;
                        fill++;
                        if ((int'(fill) + 1) * ENTRY_BYTES_DEF > PAGE_BYTES_DEF)
                            close_page(r);
                        if (entries != '1)
                            entries++;
                        if (st == ST_ARMED) begin
                            if (fires(w)) begin
                                r.trigger_hit = 1'b1;
                                hit_cnt++;
                                budget = BUDGET_W'(cfg.post_kib) << KIB_SHIFT;
                                run_state = ST_CAPT;
                            end
                        end else if (st == ST_CAPT) begin
                            if (budget <= ENTRY_BYTES_DEF) begin
                                run_state = ST_IDLE;
                                close_page(r);
                                r.capture_end = 1'b1;
                                end_cnt++;
                            end else begin
                                budget = budget - BUDGET_W'(ENTRY_BYTES_DEF);
                            end
                        end
                    end
                end
                CMD_START: begin
                    if (run_state != ST_REC) begin
                        start_time = w.now_ms;
                        run_state = ST_REC;
                        fill = '0;
                    end
                end
                CMD_ARM: begin
                    if (run_state == ST_IDLE && cfg.log_mode == MODE_TRIGGERED) begin
                        start_time = w.now_ms;
                        run_state = ST_ARMED;
                        fill = '0;
                        budget = '0;
                    end
                end
                default: begin
                    if (run_state != ST_IDLE) begin
                        run_state = ST_IDLE;
                        close_page(r);
                    end
                end
            endcase
            r.mode_now = run_state;
            r.total_entries = entries;
            r.total_wraps = wraps;
            expected_q.push_back(r);
        endfunction

        function void same_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_outcome(t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected: %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            same_field("logged", 64'(want.logged), 64'(got.logged));
            same_field("rel_time", 64'(want.rel_time), 64'(got.rel_time));
            same_field("slot", 64'(want.slot), 64'(got.slot));
            same_field("page_done", 64'(want.page_done), 64'(got.page_done));
            same_field("page_number", 64'(want.page_number), 64'(got.page_number));
            same_field("trigger_hit", 64'(want.trigger_hit), 64'(got.trigger_hit));
            same_field("capture_end", 64'(want.capture_end), 64'(got.capture_end));
            same_field("mode_now", 64'(want.mode_now), 64'(got.mode_now));
            same_field("total_entries", 64'(want.total_entries), 64'(got.total_entries));
            same_field("total_wraps", 64'(want.total_wraps), 64'(got.total_wraps));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_word            i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_word           o_out_word;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    frame_log_checker    tracker;
    bit                  calm = 1'b0;
    bit                  stall_request = 1'b0;
    logic [31:0]         wall_ms = '0;
    int                  settings_done = 0;

    can_frame_capture_trigger DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 33);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                tracker.check_outcome(o_out_word);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("can_frame_capture_trigger regression: fail");
        $finish;
    end

    function automatic t_in_word pack_word(logic [1:0] cmd, logic [2:0] bus,
                                           logic [28:0] ident, logic [3:0] dlc,
                                           logic [63:0] pl, logic [31:0] now);
        t_in_word w;
        w.command = cmd;
        w.src_bus = bus;
        w.frame_ident = ident;
        w.length_code = dlc;
        w.payload = pl;
        w.now_ms = now;
        return w;
    endfunction

    // mostly frames; leave idle quickly with start or arm; aim at the trigger, more often when armed
    function automatic t_in_word random_word();
        t_in_word   w;
        int         roll;
        int         idx;
        bit         aim;
        logic [7:0] b;
        if ($urandom_range(99) < 3)
            wall_ms = $urandom;
        else
            wall_ms = wall_ms + $urandom_range(0, 40);
        w = pack_word(CMD_FRAME, 3'($urandom_range(0, 7)),
                      $urandom_range(0, 1) ? 29'($urandom_range(0, 2047)) : 29'($urandom),
                      ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8))
                                                 : 4'($urandom_range(9, 15)),
                      {$urandom, $urandom}, wall_ms);
        roll = $urandom_range(99);
        if (tracker.run_state == ST_IDLE && roll < 40)
            w.command = (tracker.cfg.log_mode == MODE_TRIGGERED && roll < 30) ? CMD_ARM
                                                                             : CMD_START;
        else if (roll < 84)
            w.command = CMD_FRAME;
        else if (roll < 90)
            w.command = CMD_START;
        else if (roll < 95)
            w.command = CMD_ARM;
        else
            w.command = CMD_STOP;
        aim = $urandom_range(99) < ((tracker.run_state == ST_ARMED) ? 45 : 10);
        if (w.command == CMD_FRAME && aim) begin
            idx = int'(tracker.cfg.trig_byte_index);
            if (tracker.cfg.trig_bus < 8)
                w.src_bus = tracker.cfg.trig_bus[2:0];
            w.frame_ident = tracker.cfg.trig_ident;
            case ($urandom_range(0, 3))
                0:       b = tracker.cfg.trig_operand;
                1:       b = tracker.cfg.trig_operand + 8'd1;
                2:       b = tracker.cfg.trig_operand - 8'd1;
                default: b = 8'($urandom_range(0, 255));
            endcase
            w.payload[8*idx +: 8] = b;
            if ($urandom_range(0, 3) != 0)
                w.length_code = 4'($urandom_range(idx + 1, 15));
            else
                w.length_code = 4'($urandom_range(0, idx));
        end
        return w;
    endfunction

    // hold valid and payload until the word is taken
    task automatic send_word(t_in_word w);
        while (!calm && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        tracker.log_command(w);
        @(negedge i_clk);
    endtask

    // stop sending and let every expected word come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_reg(logic [2:0] idx, logic [31:0] value);
        logic [31:0] readback;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        tracker.set_register(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        readback = prdata;
        if (readback !== tracker.reg_image(idx)) begin
            tracker.errors++;
            $display("%0t: register %0d readback: expected %0h, actual %0h",
                     $time, idx, tracker.reg_image(idx), readback);
        end
    endtask

    // phase -1 is the directed trigger setup; 1..3 are the extremes
    task automatic apply_setting(int phase);
        t_cfg c;
        c.bus_enable = ($urandom_range(0, 3) == 0) ? BUS_EN_RST : 6'($urandom_range(0, 63));
        c.log_mode = ($urandom_range(0, 4) < 3) ? MODE_TRIGGERED : 2'($urandom_range(0, 3));
        c.trig_bus = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 5));
        c.trig_ident = $urandom_range(0, 1) ? 29'($urandom_range(0, 2047)) : 29'($urandom);
        c.trig_byte_index = 3'($urandom_range(0, 7));
        c.trig_compare = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
        c.trig_operand = 8'($urandom_range(0, 255));
        c.post_kib = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(2, 8))
                                                 : 16'($urandom_range(0, 1));
        case (phase)
            -1: begin
                c = '0;
                c.bus_enable = BUS_EN_RST;
                c.log_mode = MODE_TRIGGERED;
                c.trig_bus = 8'd2;
                c.trig_ident = 29'h123;
                c.trig_byte_index = 3'd3;
                c.trig_compare = CMP_EQ;
                c.trig_operand = 8'h5A;
            end
            1: c = '1;
            2: begin
                c.log_mode = MODE_TRIGGERED;
                c.trig_compare = CMP_ANY;
                c.post_kib = 16'hFFFF;
            end
            3: c = '0;
            default: ;
        endcase
        program_reg(REG_BUS_EN, 32'(c.bus_enable));
        program_reg(REG_LOG_MODE, 32'(c.log_mode));
        program_reg(REG_TRIG_BUS, 32'(c.trig_bus));
        program_reg(REG_TRIG_IDENT, 32'(c.trig_ident));
        program_reg(REG_TRIG_INDEX, 32'(c.trig_byte_index));
        program_reg(REG_TRIG_CMP, 32'(c.trig_compare));
        program_reg(REG_TRIG_OPND, 32'(c.trig_operand));
        program_reg(REG_POST_KIB, 32'(c.post_kib));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        settings_done++;
    endtask

    initial begin
        int ph;
        int k;
        tracker = new();
        wall_ms = $urandom;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: manual mode, all buses enabled
        send_word(pack_word(CMD_FRAME, 3'd0, 29'd0, 4'd8, 64'd0, 32'd50));
        send_word(pack_word(CMD_STOP, 3'd0, 29'd0, 4'd0, 64'd0, 32'd60));
        send_word(pack_word(CMD_ARM, 3'd0, 29'd0, 4'd0, 64'd0, 32'd70));
        send_word(pack_word(CMD_START, 3'd0, 29'd0, 4'd0, 64'd0, 32'd1000));
        send_word(pack_word(CMD_FRAME, 3'd0, 29'd0, 4'd0, 64'd0, 32'd1000));
        send_word(pack_word(CMD_FRAME, 3'd5, '1, 4'd15, '1, '1));
        send_word(pack_word(CMD_FRAME, 3'd6, 29'd7, 4'd8, 64'd1, 32'd1001));
        send_word(pack_word(CMD_FRAME, 3'd7, 29'd7, 4'd8, 64'd1, 32'd1002));
        send_word(pack_word(CMD_START, 3'd0, 29'd0, 4'd0, 64'd0, 32'd5));
        // fill the rest of the first page so it flushes on its twelfth entry
        for (k = 0; k < 10; k++)
            send_word(pack_word(CMD_FRAME, 3'(k % 6), 29'($urandom), 4'(k),
                                {$urandom, $urandom}, 32'(1003 + k)));
        send_word(pack_word(CMD_FRAME, 3'd1, 29'h7FF, 4'd2, 64'hBEEF, 32'd1100));
        send_word(pack_word(CMD_STOP, 3'd0, 29'd0, 4'd0, 64'd0, 32'd1200));
        drain();

        // trigger on bus 2, ident 0x123, byte 3 equal to 0x5A, no post-trigger budget
        apply_setting(-1);
        send_word(pack_word(CMD_ARM, 3'd0, 29'd0, 4'd0, 64'd0, 32'd2000));
        send_word(pack_word(CMD_FRAME, 3'd2, 29'h123, 4'd3, 64'h5A00_0000, 32'd2010));
        send_word(pack_word(CMD_FRAME, 3'd2, 29'h123, 4'd8, 64'h5A00_0000, 32'd2020));
        send_word(pack_word(CMD_FRAME, 3'd3, 29'h55, 4'd1, 64'h1, 32'd2030));
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 0);
            apply_setting(ph);
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                if (ph == 4 && k == 20)
                    stall_request = 1'b1;
                send_word(random_word());
            end
            drain();
        end
        calm = 1'b0;
        repeat (6) @(posedge i_clk);

        $display("Exercised %0d words over %0d register settings: %0d entries logged, %0d pages flushed.",
                 tracker.words_in, settings_done, tracker.logged_cnt, tracker.flush_cnt);
        $display("Triggers fired %0d times, captures ran out %0d times, %0d mismatches.",
                 tracker.hit_cnt, tracker.end_cnt, tracker.errors);
        if (tracker.errors == 0 && tracker.expected_q.size() == 0)
            $display("can_frame_capture_trigger regression: pass");
        else
            $display("can_frame_capture_trigger regression: fail");
        $finish;
    end

endmodule
